// ----- rtl/ppu_pkg.sv -----
// Package for the perspective point projection unit: widths, register
// indexes, reset values and request/response payload types.
// No dependencies.
`default_nettype none

package ppu_pkg;

   // Field formats
   localparam int COORD_W   = 16;   // signed Q8.8 coordinates
   localparam int TRIG_W    = 16;   // signed Q2.14 sines and cosines
   localparam int TRIG_FRAC = 14;

   // Configuration port
   localparam int CSR_W     = 48;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_POSITION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_OFFSET  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_ANGLES      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_ANGLES      = 2'd3;

   localparam logic [CSR_W-1:0] COS_ANGLES_RESET = 48'h4000_4000_4000;

   // Datapath widths. Point minus camera needs one extra bit; the rotation
   // passes widen to 20, 21 and 22 bits and never reach the 2^30 clamp.
   localparam int DIFF_W = COORD_W + 1;   // x, y, z
   localparam int ROT1_W = 20;            // a, b
   localparam int ROT2_W = 21;            // c, dx
   localparam int ROT3_W = 22;            // dy, dz

   // Quotient bits kept by the divider; a larger quotient always saturates.
   localparam int QUOT_W = COORD_W + 1;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } ppu_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] screen_x;
      logic signed [COORD_W-1:0] screen_y;
      logic                      depth_zero;
      logic                      saturated;
   } ppu_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/perspective_point_projection_unit.sv -----
// Top level of the perspective point projection unit: configuration
// registers, camera subtract, three rotation passes, projection, output.
// Depends on ppu_pkg, ppu_rotate and ppu_project.
`default_nettype none

// Perspective point projection unit. Takes one world point (signed Q8.8) per
// request, subtracts the camera position, rotates it by the camera angles
// (Q2.14 sines/cosines, z then y then x) and projects it onto the display
// plane: screen = ez*d/dz + e, rounded, saturated to Q8.8. A zero rotated
// depth returns zeros with depth_zero set; any clipping sets saturated.
// Throughput is one point per clock while the output is not stalled. The
// path from request to response has 1 subtract stage, 2 stages per rotation
// pass, 1 product and 1 prep stage for the divide, 17 divider stages (one
// quotient bit each), 1 saturation stage and the response register. The
// last pipeline stage doubles as a skid slot, so requests keep flowing while
// a response waits until the next response reaches that last stage.
// Configuration writes take effect at once and must only be done while no
// point is in flight; no clearing pass is needed after reset.
module perspective_point_projection_unit
   import ppu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  ppu_req_type          req_payload,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ppu_rsp_type          rsp_payload,

   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   // ---------------- configuration registers
   logic [CSR_W-1:0] camera_position_ff, display_offset_ff, cos_angles_ff, sin_angles_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_position_ff <= '0;
         display_offset_ff  <= '0;
         cos_angles_ff      <= COS_ANGLES_RESET;
         sin_angles_ff      <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CAMERA_POSITION: camera_position_ff <= csr_write_data;
            CSR_DISPLAY_OFFSET:  display_offset_ff  <= csr_write_data;
            CSR_COS_ANGLES:      cos_angles_ff      <= csr_write_data;
            CSR_SIN_ANGLES:      sin_angles_ff      <= csr_write_data;
            default:             camera_position_ff <= camera_position_ff;
         endcase
      end
   end

   // field views (field 0 in the low bits)
   logic signed [COORD_W-1:0] cam_x, cam_y, cam_z, ex, ey, ez;
   logic signed [TRIG_W-1:0]  cx, cy, cz, sx, sy, sz;

   assign cam_x = camera_position_ff[COORD_W-1:0];
   assign cam_y = camera_position_ff[2*COORD_W-1:COORD_W];
   assign cam_z = camera_position_ff[3*COORD_W-1:2*COORD_W];
   assign ex    = display_offset_ff[COORD_W-1:0];
   assign ey    = display_offset_ff[2*COORD_W-1:COORD_W];
   assign ez    = display_offset_ff[3*COORD_W-1:2*COORD_W];
   assign cx    = cos_angles_ff[TRIG_W-1:0];
   assign cy    = cos_angles_ff[2*TRIG_W-1:TRIG_W];
   assign cz    = cos_angles_ff[3*TRIG_W-1:2*TRIG_W];
   assign sx    = sin_angles_ff[TRIG_W-1:0];
   assign sy    = sin_angles_ff[2*TRIG_W-1:TRIG_W];
   assign sz    = sin_angles_ff[3*TRIG_W-1:2*TRIG_W];

   // ---------------- flow control
   // The whole pipeline moves on one enable. It may move whenever its last
   // stage is empty or that stage's response is handed to the output register.
   logic        advance;
   logic        pipe_valid;
   ppu_rsp_type pipe_rsp;
   logic        out_load;
   logic        rsp_valid_ff, rsp_valid_in;
   ppu_rsp_type rsp_payload_ff;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign advance   = !pipe_valid || out_load;
   assign req_ready = advance;

   // ---------------- camera subtract (never near the 2^30 clamp)
   logic signed [COORD_W-1:0] pt_x, pt_y, pt_z;
   logic signed [DIFF_W-1:0]  diff_x_ff, diff_y_ff, diff_z_ff;
   logic signed [DIFF_W-1:0]  diff_x_in, diff_y_in, diff_z_in;
   logic                      diff_valid_ff;

   assign pt_x      = req_payload.point_x;
   assign pt_y      = req_payload.point_y;
   assign pt_z      = req_payload.point_z;
   assign diff_x_in = DIFF_W'(pt_x) - DIFF_W'(cam_x);
   assign diff_y_in = DIFF_W'(pt_y) - DIFF_W'(cam_y);
   assign diff_z_in = DIFF_W'(pt_z) - DIFF_W'(cam_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
      end else if (advance) begin
         diff_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_x_ff <= diff_x_in;
         diff_y_ff <= diff_y_in;
         diff_z_ff <= diff_z_in;
      end
   end

   // ---------------- rotation about z: a, b (z rides along)
   logic                     rot1_valid;
   logic signed [ROT1_W-1:0] rot_a, rot_b;
   logic signed [DIFF_W-1:0] rot1_z;

   ppu_rotate #(
      .IN_W   (DIFF_W),
      .OUT_W  (ROT1_W),
      .PASS_W (DIFF_W)
   ) u_rot_z (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (diff_valid_ff),
      .ka        (sz),
      .kb        (cz),
      .kc        (cz),
      .kd        (sz),
      .va        (diff_y_ff),
      .vb        (diff_x_ff),
      .vc        (diff_y_ff),
      .vd        (diff_x_ff),
      .pass_in   (diff_z_ff),
      .out_valid (rot1_valid),
      .sum_out   (rot_a),
      .diff_out  (rot_b),
      .pass_out  (rot1_z)
   );

   // ---------------- rotation about y: c, dx (b rides along)
   logic                     rot2_valid;
   logic signed [ROT2_W-1:0] rot_c, rot_dx;
   logic signed [ROT1_W-1:0] rot2_b;
   logic signed [ROT1_W-1:0] rot1_z_ext;

   assign rot1_z_ext = ROT1_W'(rot1_z);

   ppu_rotate #(
      .IN_W   (ROT1_W),
      .OUT_W  (ROT2_W),
      .PASS_W (ROT1_W)
   ) u_rot_y (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (rot1_valid),
      .ka        (cy),
      .kb        (sy),
      .kc        (cy),
      .kd        (sy),
      .va        (rot1_z_ext),
      .vb        (rot_a),
      .vc        (rot_a),
      .vd        (rot1_z_ext),
      .pass_in   (rot_b),
      .out_valid (rot2_valid),
      .sum_out   (rot_c),
      .diff_out  (rot_dx),
      .pass_out  (rot2_b)
   );

   // ---------------- rotation about x: dy, dz (dx rides along)
   logic                     rot3_valid;
   logic signed [ROT3_W-1:0] rot_dy, rot_dz;
   logic signed [ROT2_W-1:0] rot3_dx;
   logic signed [ROT2_W-1:0] rot2_b_ext;

   assign rot2_b_ext = ROT2_W'(rot2_b);

   ppu_rotate #(
      .IN_W   (ROT2_W),
      .OUT_W  (ROT3_W),
      .PASS_W (ROT2_W)
   ) u_rot_x (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (rot2_valid),
      .ka        (sx),
      .kb        (cx),
      .kc        (cx),
      .kd        (sx),
      .va        (rot_c),
      .vb        (rot2_b_ext),
      .vc        (rot_c),
      .vd        (rot2_b_ext),
      .pass_in   (rot_dx),
      .out_valid (rot3_valid),
      .sum_out   (rot_dy),
      .diff_out  (rot_dz),
      .pass_out  (rot3_dx)
   );

   // ---------------- perspective divide
   ppu_project u_project (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (rot3_valid),
      .ex        (ex),
      .ey        (ey),
      .ez        (ez),
      .dx        (rot3_dx),
      .dy        (rot_dy),
      .dz        (rot_dz),
      .out_valid (pipe_valid),
      .out_rsp   (pipe_rsp)
   );

   // ---------------- response register
   assign rsp_valid_in = out_load ? pipe_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && pipe_valid) begin
         rsp_payload_ff <= pipe_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------- assertions
   // a consumer that is ready never back-pressures the request side
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side ready");

   // zero depth gives zero coordinates and no clip flag
   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.depth_zero) |->
         (rsp_payload.screen_x == '0 && rsp_payload.screen_y == '0 &&
          !rsp_payload.saturated))
      else $error("zero depth response not cleared");

   // a clipped response holds a rail value on at least one axis
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.saturated) |->
         (rsp_payload.screen_x == {1'b0, {(COORD_W-1){1'b1}}} ||
          rsp_payload.screen_x == {1'b1, {(COORD_W-1){1'b0}}} ||
          rsp_payload.screen_y == {1'b0, {(COORD_W-1){1'b1}}} ||
          rsp_payload.screen_y == {1'b1, {(COORD_W-1){1'b0}}}))
      else $error("saturated flag without rail value");

endmodule

`default_nettype wire

// ----- rtl/ppu_rotate.sv -----
// One rotation pass: two product pairs, then sum/difference rounded back
// to coordinate format. Two register stages. Uses ppu_pkg.
`default_nettype none

module ppu_rotate
   import ppu_pkg::*;
#(
   parameter int IN_W   = 17,
   parameter int OUT_W  = 20,
   parameter int PASS_W = 17
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic signed [TRIG_W-1:0] ka,
   input  logic signed [TRIG_W-1:0] kb,
   input  logic signed [TRIG_W-1:0] kc,
   input  logic signed [TRIG_W-1:0] kd,
   input  logic signed [IN_W-1:0]   va,
   input  logic signed [IN_W-1:0]   vb,
   input  logic signed [IN_W-1:0]   vc,
   input  logic signed [IN_W-1:0]   vd,
   input  logic signed [PASS_W-1:0] pass_in,
   output logic                     out_valid,
   output logic signed [OUT_W-1:0]  sum_out,
   output logic signed [OUT_W-1:0]  diff_out,
   output logic signed [PASS_W-1:0] pass_out
);

   localparam int PROD_W = TRIG_W + IN_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam logic signed [SUM_W-1:0] HALF =
      {{(SUM_W-TRIG_FRAC){1'b0}}, 1'b1, {(TRIG_FRAC-1){1'b0}}};

   // stage 1: products
   logic                     prod_valid_ff;
   logic signed [PROD_W-1:0] prod_a_ff, prod_b_ff, prod_c_ff, prod_d_ff;
   logic signed [PROD_W-1:0] prod_a_in, prod_b_in, prod_c_in, prod_d_in;
   logic signed [PASS_W-1:0] pass1_ff;

   // stage 2: rounded results
   logic                     res_valid_ff;
   logic signed [OUT_W-1:0]  sum_ff, diff_ff, sum_in, diff_in;
   logic signed [PASS_W-1:0] pass2_ff;

   logic signed [SUM_W-1:0]  sum_p, sum_m, rnd_p, rnd_m;

   assign prod_a_in = ka * va;
   assign prod_b_in = kb * vb;
   assign prod_c_in = kc * vc;
   assign prod_d_in = kd * vd;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         prod_c_ff <= prod_c_in;
         prod_d_ff <= prod_d_in;
         pass1_ff  <= pass_in;
      end
   end

   // round half up: floor((v + 2^(F-1)) / 2^F)
   always_comb begin
      sum_p   = SUM_W'(prod_a_ff) + SUM_W'(prod_b_ff);
      sum_m   = SUM_W'(prod_c_ff) - SUM_W'(prod_d_ff);
      rnd_p   = (sum_p + HALF) >>> TRIG_FRAC;
      rnd_m   = (sum_m + HALF) >>> TRIG_FRAC;
      sum_in  = rnd_p[OUT_W-1:0];
      diff_in = rnd_m[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (advance) begin
         res_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff   <= sum_in;
         diff_ff  <= diff_in;
         pass2_ff <= pass1_ff;
      end
   end

   assign out_valid = res_valid_ff;
   assign sum_out   = sum_ff;
   assign diff_out  = diff_ff;
   assign pass_out  = pass2_ff;

endmodule

`default_nettype wire

// ----- rtl/ppu_project.sv -----
// Perspective divide for both screen axes: ez*d product, magnitude prep,
// one quotient bit per stage, then sign, offset and saturation. Uses ppu_pkg.
`default_nettype none

module ppu_project
   import ppu_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] ex,
   input  logic signed [COORD_W-1:0] ey,
   input  logic signed [COORD_W-1:0] ez,
   input  logic signed [ROT2_W-1:0]  dx,
   input  logic signed [ROT3_W-1:0]  dy,
   input  logic signed [ROT3_W-1:0]  dz,
   output logic                      out_valid,
   output ppu_rsp_type               out_rsp
);

   localparam int NUM_W = COORD_W + ROT3_W;   // ez * d
   localparam int REM_W = NUM_W + 2;          // 2|n| + |dz|
   localparam int DEN_W = ROT3_W + 1;         // 2|dz|
   localparam int RES_W = QUOT_W + 2;
   localparam logic signed [RES_W-1:0] SCR_MAX = RES_W'((2 ** (COORD_W - 1)) - 1);
   localparam logic signed [RES_W-1:0] SCR_MIN = -RES_W'(2 ** (COORD_W - 1));

   // product stage
   logic                    mul_valid_ff;
   logic signed [NUM_W-1:0] num_ff [2];
   logic signed [NUM_W-1:0] num_in [2];
   logic signed [ROT3_W-1:0] mul_dz_ff;

   // prep stage
   logic                    prep_valid_ff;
   logic [REM_W-1:0]        prep_rem_ff [2];
   logic [REM_W-1:0]        prep_rem_in [2];
   logic [DEN_W-1:0]        prep_den_ff, prep_den_in;
   logic [1:0]              prep_neg_ff, prep_neg_in, prep_ovf_ff, prep_ovf_in;
   logic                    prep_zero_ff, prep_zero_in;
   logic [NUM_W-1:0]        mag_n [2];
   logic [ROT3_W-1:0]       mag_d;

   // divider stages
   logic [REM_W-1:0]        dv_rem_ff  [QUOT_W][2];
   logic [QUOT_W-1:0]       dv_quot_ff [QUOT_W][2];
   logic [DEN_W-1:0]        dv_den_ff  [QUOT_W];
   logic [1:0]              dv_neg_ff  [QUOT_W];
   logic [1:0]              dv_ovf_ff  [QUOT_W];
   logic [QUOT_W-1:0]       dv_zero_ff;
   logic [QUOT_W-1:0]       dv_valid_ff;

   // final stage
   logic                    fin_valid_ff;
   ppu_rsp_type             fin_rsp_ff, fin_rsp_in;

   // --- product
   assign num_in[0] = ez * dx;
   assign num_in[1] = ez * dy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff[0] <= num_in[0];
         num_ff[1] <= num_in[1];
         mul_dz_ff <= dz;
      end
   end

   // --- prep: rounded quotient is floor((2|n| + |dz|) / (2|dz|))
   always_comb begin
      mag_d        = mul_dz_ff[ROT3_W-1] ? ROT3_W'(-mul_dz_ff) : ROT3_W'(mul_dz_ff);
      prep_den_in  = {mag_d, 1'b0};
      prep_zero_in = (mul_dz_ff == '0);
      for (int l = 0; l < 2; l++) begin
         mag_n[l]       = num_ff[l][NUM_W-1] ? NUM_W'(-num_ff[l]) : NUM_W'(num_ff[l]);
         prep_rem_in[l] = {1'b0, mag_n[l], 1'b0} + REM_W'(mag_d);
         prep_neg_in[l] = num_ff[l][NUM_W-1] ^ mul_dz_ff[ROT3_W-1];
         prep_ovf_in[l] = prep_rem_in[l] >= (REM_W'(prep_den_in) << QUOT_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (advance) begin
         prep_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_rem_ff[0] <= prep_rem_in[0];
         prep_rem_ff[1] <= prep_rem_in[1];
         prep_den_ff    <= prep_den_in;
         prep_neg_ff    <= prep_neg_in;
         prep_ovf_ff    <= prep_ovf_in;
         prep_zero_ff   <= prep_zero_in;
      end
   end

   // --- restoring division, MSB first
   for (genvar k = 0; k < QUOT_W; k++) begin : g_div
      localparam int BIT = QUOT_W - 1 - k;
      logic [REM_W-1:0]  src_rem  [2];
      logic [QUOT_W-1:0] src_quot [2];
      logic [DEN_W-1:0]  src_den;
      logic [1:0]        src_neg, src_ovf;
      logic              src_zero, src_valid;
      logic [REM_W:0]    trial [2];
      logic [REM_W-1:0]  rem_in [2];
      logic [QUOT_W-1:0] quot_in [2];

      if (k == 0) begin : g_first
         assign src_rem[0]  = prep_rem_ff[0];
         assign src_rem[1]  = prep_rem_ff[1];
         assign src_quot[0] = '0;
         assign src_quot[1] = '0;
         assign src_den     = prep_den_ff;
         assign src_neg     = prep_neg_ff;
         assign src_ovf     = prep_ovf_ff;
         assign src_zero    = prep_zero_ff;
         assign src_valid   = prep_valid_ff;
      end else begin : g_next
         assign src_rem[0]  = dv_rem_ff[k-1][0];
         assign src_rem[1]  = dv_rem_ff[k-1][1];
         assign src_quot[0] = dv_quot_ff[k-1][0];
         assign src_quot[1] = dv_quot_ff[k-1][1];
         assign src_den     = dv_den_ff[k-1];
         assign src_neg     = dv_neg_ff[k-1];
         assign src_ovf     = dv_ovf_ff[k-1];
         assign src_zero    = dv_zero_ff[k-1];
         assign src_valid   = dv_valid_ff[k-1];
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            trial[l] = {1'b0, src_rem[l]} - ((REM_W+1)'(src_den) << BIT);
            if (!trial[l][REM_W]) begin
               rem_in[l]  = trial[l][REM_W-1:0];
               quot_in[l] = {src_quot[l][QUOT_W-2:0], 1'b1};
            end else begin
               rem_in[l]  = src_rem[l];
               quot_in[l] = {src_quot[l][QUOT_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            dv_valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_rem_ff[k][0]  <= rem_in[0];
            dv_rem_ff[k][1]  <= rem_in[1];
            dv_quot_ff[k][0] <= quot_in[0];
            dv_quot_ff[k][1] <= quot_in[1];
            dv_den_ff[k]     <= src_den;
            dv_neg_ff[k]     <= src_neg;
            dv_ovf_ff[k]     <= src_ovf;
            dv_zero_ff[k]    <= src_zero;
         end
      end
   end

   // --- sign, display offset, saturation
   logic signed [RES_W-1:0]   sq [2];
   logic signed [RES_W-1:0]   rr [2];
   logic signed [COORD_W-1:0] ofs [2];
   logic signed [COORD_W-1:0] scr [2];
   logic [1:0]                sat;
   logic                      last_zero;

   assign ofs[0]    = ex;
   assign ofs[1]    = ey;
   assign last_zero = dv_zero_ff[QUOT_W-1];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         sq[l] = $signed(RES_W'(dv_quot_ff[QUOT_W-1][l]));
         if (dv_neg_ff[QUOT_W-1][l]) begin
            sq[l] = -sq[l];
         end
         rr[l]  = sq[l] + RES_W'(ofs[l]);
         sat[l] = 1'b1;
         if (dv_ovf_ff[QUOT_W-1][l]) begin
            scr[l] = dv_neg_ff[QUOT_W-1][l] ? SCR_MIN[COORD_W-1:0] : SCR_MAX[COORD_W-1:0];
         end else if (rr[l] > SCR_MAX) begin
            scr[l] = SCR_MAX[COORD_W-1:0];
         end else if (rr[l] < SCR_MIN) begin
            scr[l] = SCR_MIN[COORD_W-1:0];
         end else begin
            scr[l] = rr[l][COORD_W-1:0];
            sat[l] = 1'b0;
         end
      end
      fin_rsp_in.screen_x   = last_zero ? '0 : scr[0];
      fin_rsp_in.screen_y   = last_zero ? '0 : scr[1];
      fin_rsp_in.depth_zero = last_zero;
      fin_rsp_in.saturated  = !last_zero && (sat != 2'b00);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (advance) begin
         fin_valid_ff <= dv_valid_ff[QUOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fin_rsp_ff <= fin_rsp_in;
      end
   end

   assign out_valid = fin_valid_ff;
   assign out_rsp   = fin_rsp_ff;

endmodule

`default_nettype wire

// ----- tb/perspective_point_projection_unit_tb.sv -----
// Testbench for the perspective point projection unit: drives points with
// random gaps, predicts each projection in fixed point and checks responses.
// Depends on ppu_pkg and perspective_point_projection_unit.
`default_nettype none

module perspective_point_projection_unit_tb;
   import ppu_pkg::*;

   localparam longint CLAMP_MAX = 64'sd1073741823;
   localparam int     DRAIN_CYCLES = 40;   // longer than the pipeline latency

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   ppu_req_type          req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   ppu_rsp_type          rsp_payload;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;

   perspective_point_projection_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Shadow copy of the configuration registers
   logic [CSR_W-1:0] cam_reg, disp_reg, cos_reg, sin_reg;

   ppu_req_type pending_points[$];
   ppu_rsp_type expected_projections[$];
   int  mismatch_count = 0;
   int  sent_count = 0;
   bit  stimulus_done = 0;
   bit  hold_off = 0;       // sender pauses while set
   bit  req_taken = 0;      // request accepted at the last rising edge
   bit  clip_seen;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Clamp an intermediate to the +/- (2^30 - 1) working range
   function automatic longint clamp_mid(longint v);
      if (v > CLAMP_MAX) begin clip_seen = 1; return CLAMP_MAX; end
      if (v < -CLAMP_MAX) begin clip_seen = 1; return -CLAMP_MAX; end
      return v;
   endfunction

   // Q2.14 product sum back to Q8.8, round half up (floor of v + half)
   function automatic longint trig_round(longint v);
      longint t;
      t = v + (64'sd1 <<< (TRIG_FRAC - 1));
      return clamp_mid(t >>> TRIG_FRAC);
   endfunction

   // ez*d/dz rounded half away from zero, plus offset, saturated to Q8.8
   function automatic longint screen_coord(longint ez, longint d, longint dz, longint e);
      longint n, an, ad, q, r;
      n  = ez * d;
      an = (n < 0) ? -n : n;
      ad = (dz < 0) ? -dz : dz;
      q  = (2 * an + ad) / (2 * ad);
      if ((n < 0) != (dz < 0)) q = -q;
      r = q + e;
      if (r > 32767) begin clip_seen = 1; return 32767; end
      if (r < -32768) begin clip_seen = 1; return -32768; end
      return r;
   endfunction

   function automatic longint coord_field(logic [CSR_W-1:0] r, int i);
      logic signed [COORD_W-1:0] f;
      f = r[i*COORD_W +: COORD_W];
      return longint'(f);
   endfunction

   function automatic longint trig_field(logic [CSR_W-1:0] r, int i);
      logic signed [TRIG_W-1:0] f;
      f = r[i*TRIG_W +: TRIG_W];
      return longint'(f);
   endfunction

   function automatic ppu_rsp_type project_point(ppu_req_type p);
      ppu_rsp_type res;
      longint cx, cy, cz, sx, sy, sz, x, y, z, a, b, c, dx, dy, dz;
      cx = trig_field(cos_reg, 0); cy = trig_field(cos_reg, 1); cz = trig_field(cos_reg, 2);
      sx = trig_field(sin_reg, 0); sy = trig_field(sin_reg, 1); sz = trig_field(sin_reg, 2);
      clip_seen = 0;
      x = clamp_mid(longint'(p.point_x) - coord_field(cam_reg, 0));
      y = clamp_mid(longint'(p.point_y) - coord_field(cam_reg, 1));
      z = clamp_mid(longint'(p.point_z) - coord_field(cam_reg, 2));
      a  = trig_round(sz * y + cz * x);
      b  = trig_round(cz * y - sz * x);
      c  = trig_round(cy * z + sy * a);
      dx = trig_round(cy * a - sy * z);
      dy = trig_round(sx * c + cx * b);
      dz = trig_round(cx * c - sx * b);
      res = '0;
      if (dz == 0) begin
         res.depth_zero = 1'b1;   // zero depth: zeros, no clip flag
      end else begin
         res.screen_x = COORD_W'(screen_coord(coord_field(disp_reg, 2), dx, dz,
                                              coord_field(disp_reg, 0)));
         res.screen_y = COORD_W'(screen_coord(coord_field(disp_reg, 2), dy, dz,
                                              coord_field(disp_reg, 1)));
         res.saturated = clip_seen;
      end
      return res;
   endfunction

   // Driver: one request from the queue, random gaps, valid held until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid && !req_taken) begin
         // hold payload until accepted
      end else if (!hold_off && pending_points.size() > 0 && $urandom_range(0, 99) < 70) begin
         req_valid   <= 1;
         req_payload <= pending_points.pop_front();
      end else if (!hold_off && pending_points.size() > 0 && $urandom_range(0, 99) < 5) begin
         req_valid <= 0;
         repeat ($urandom_range(5, 30)) @(negedge clock);   // occasional long gap
      end else begin
         req_valid <= 0;
      end
   end

   // Receiver backpressure: mostly ready, short stalls, rare long ones
   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else if ($urandom_range(0, 99) < 3) begin
         rsp_ready <= 0;
         repeat ($urandom_range(5, 40)) @(negedge clock);
      end else rsp_ready <= ($urandom_range(0, 99) < 75);
   end

   // Prediction happens at acceptance, so config in force is the right one
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         expected_projections.push_back(project_point(req_payload));
         sent_count++;
      end
   end

   // Monitor: compare each response with the oldest prediction
   always @(posedge clock) begin
      ppu_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_projections.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected response %h", rsp_payload);
         end else begin
            want = expected_projections.pop_front();
            if (want.screen_x !== rsp_payload.screen_x || want.screen_y !== rsp_payload.screen_y ||
                want.depth_zero !== rsp_payload.depth_zero ||
                want.saturated !== rsp_payload.saturated) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: exp x=%0d y=%0d dz=%b sat=%b, got x=%0d y=%0d dz=%b sat=%b",
                           want.screen_x, want.screen_y, want.depth_zero, want.saturated,
                           rsp_payload.screen_x, rsp_payload.screen_y,
                           rsp_payload.depth_zero, rsp_payload.saturated);
            end
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(negedge clock);
      csr_write_enable <= 0;
      case (idx)
         CSR_CAMERA_POSITION: cam_reg  = val;
         CSR_DISPLAY_OFFSET:  disp_reg = val;
         CSR_COS_ANGLES:      cos_reg  = val;
         default:             sin_reg  = val;
      endcase
   endtask

   // Block idle: queue empty, driver not holding, no predictions left
   task automatic wait_idle();
      while (pending_points.size() > 0 || req_valid || expected_projections.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic ppu_req_type make_point(int sx, int sy, int sz);
      ppu_req_type p;
      p.point_x = COORD_W'(sx); p.point_y = COORD_W'(sy); p.point_z = COORD_W'(sz);
      return p;
   endfunction

   function automatic logic [15:0] rand_trig();
      return $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 32768) - 16384);
   endfunction

   function automatic logic [47:0] pack3(logic [15:0] a, logic [15:0] b, logic [15:0] c);
      return {c, b, a};
   endfunction

   // Random points: mostly moderate coords so projections stay in range,
   // some full-range to force clipping, some at the camera's z for zero depth.
   task automatic queue_random(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 9);
         if (k < 6)
            pending_points.push_back(make_point($urandom_range(0, 4095) - 2048,
                                                $urandom_range(0, 4095) - 2048,
                                                $urandom_range(0, 4095) - 2048));
         else if (k < 9)
            pending_points.push_back(make_point($urandom(), $urandom(), $urandom()));
         else
            pending_points.push_back(make_point($urandom(), $urandom(), 16'(cam_reg[47:32])));
      end
   endtask

   initial begin
      reset            = 1;
      req_valid        = 0;
      req_payload      = '0;
      rsp_ready        = 0;
      csr_write_enable = 0;
      csr_index        = CSR_CAMERA_POSITION;
      csr_write_data   = '0;
      cam_reg  = '0;
      disp_reg = '0;
      cos_reg  = COS_ANGLES_RESET;
      sin_reg  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed, reset config: identity rotation, zero offset -> ez=0
      pending_points.push_back(make_point(0, 0, 0));          // zero depth
      pending_points.push_back(make_point(32767, -32768, 256));
      pending_points.push_back(make_point(-32768, 32767, -1));
      wait_idle();

      // Directed with display plane at ez = 1.0: clipping and small quotients
      csr_write(CSR_DISPLAY_OFFSET, pack3(16'h0010, 16'hFFF0, 16'h0100));
      pending_points.push_back(make_point(32767, 32767, 1));  // huge quotient, clips
      pending_points.push_back(make_point(-32768, -32768, 1));
      pending_points.push_back(make_point(128, -128, 256));
      pending_points.push_back(make_point(1, -1, 2));         // small coordinates, exact quotient
      pending_points.push_back(make_point(-3, 3, -2));
      pending_points.push_back(make_point(5, 5, 0));          // zero depth
      wait_idle();

      // Extreme camera offsets push the difference past Q8.8 range
      csr_write(CSR_CAMERA_POSITION, pack3(16'h8000, 16'h7FFF, 16'h8000));
      csr_write(CSR_COS_ANGLES, pack3(16'h7FFF, 16'h8000, 16'h7FFF));
      csr_write(CSR_SIN_ANGLES, pack3(16'h8000, 16'h7FFF, 16'h8000));
      pending_points.push_back(make_point(32767, -32768, 32767));
      pending_points.push_back(make_point(-32768, 32767, -32768));
      pending_points.push_back(make_point(0, 0, 0));
      pending_points.push_back(make_point(-1, -1, -1));
      wait_idle();

      // 90 degree turn about each axis
      csr_write(CSR_CAMERA_POSITION, '0);
      csr_write(CSR_COS_ANGLES, '0);
      csr_write(CSR_SIN_ANGLES, pack3(16'h4000, 16'h4000, 16'h4000));
      csr_write(CSR_DISPLAY_OFFSET, pack3(16'h8000, 16'h7FFF, 16'h8000));
      pending_points.push_back(make_point(256, 512, 768));
      pending_points.push_back(make_point(-256, 0, 1));
      pending_points.push_back(make_point(0, 0, 0));
      wait_idle();

      // Random phases with new settings between them
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(CSR_CAMERA_POSITION, pack3(16'($urandom_range(0, 1023) - 512),
                                              16'($urandom_range(0, 1023) - 512),
                                              ph == 7 ? 16'($urandom()) :
                                                        16'($urandom_range(0, 1023) - 512)));
         csr_write(CSR_DISPLAY_OFFSET, ph == 6 ? 48'($urandom()) << 16 | 48'($urandom()) :
                   pack3(16'($urandom_range(0, 255) - 128), 16'($urandom_range(0, 255) - 128),
                         16'($urandom_range(64, 1024))));
         if (ph == 0) begin
            csr_write(CSR_COS_ANGLES, COS_ANGLES_RESET);
            csr_write(CSR_SIN_ANGLES, '0);
         end else begin
            csr_write(CSR_COS_ANGLES, pack3(rand_trig(), rand_trig(), rand_trig()));
            csr_write(CSR_SIN_ANGLES, pack3(rand_trig(), rand_trig(), rand_trig()));
         end
         queue_random(25);
         // sender stalls until the block drains, then resumes
         if (ph == 3) begin
            while (pending_points.size() > 12) @(posedge clock);
            hold_off = 1;
            while (req_valid || expected_projections.size() > 0) @(posedge clock);
            hold_off = 0;
         end
         queue_random(25);
         wait_idle();
      end

      stimulus_done = 1;
      if (mismatch_count == 0 && expected_projections.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
